// ===== hdl/ccrc_pkg.sv =====
package ccrc_pkg;

	localparam int CCRC_DEFAULT_WIDTH = 32;
	localparam int CCRC_ADDR_W        = 4;

	localparam logic [31:0] CCRC_POLY_RESET = 32'h04C1_1DB7;
	localparam logic [31:0] CCRC_INIT_RESET = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		REG_POLY        = 2'd0,
		REG_INIT        = 2'd1,
		REG_REFLECT_IN  = 2'd2,
		REG_REFLECT_OUT = 2'd3
	} reg_idx_t;

	// settings seen by the datapath, wr pulses with each register write
	typedef struct packed {
		logic [31:0] poly;
		logic [31:0] init_crc;
		logic        reflect_in;
		logic        reflect_out;
		logic        wr;
	} cfg_t;

endpackage

// ===== hdl/ccrc_regs.sv =====
module ccrc_regs import ccrc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [CCRC_ADDR_W-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic [31:0] poly_q;
	logic [31:0] init_q;
	logic        refl_in_q;
	logic        refl_out_q;
	reg_idx_t    idx;
	logic        wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[CCRC_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q     <= CCRC_POLY_RESET;
			init_q     <= CCRC_INIT_RESET;
			refl_in_q  <= 1'b0;
			refl_out_q <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_POLY:        poly_q     <= pwdata;
				REG_INIT:        init_q     <= pwdata;
				REG_REFLECT_IN:  refl_in_q  <= pwdata[0];
				REG_REFLECT_OUT: refl_out_q <= pwdata[0];
				default:         poly_q     <= poly_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_POLY:        prdata = poly_q;
			REG_INIT:        prdata = init_q;
			REG_REFLECT_IN:  prdata = {31'd0, refl_in_q};
			REG_REFLECT_OUT: prdata = {31'd0, refl_out_q};
			default:         prdata = 32'd0;
		endcase
	end

	assign cfg.poly        = poly_q;
	assign cfg.init_crc    = init_q;
	assign cfg.reflect_in  = refl_in_q;
	assign cfg.reflect_out = refl_out_q;
	assign cfg.wr          = wr_en;

endmodule

// ===== hdl/ccrc_byte_step.sv =====
module ccrc_byte_step import ccrc_pkg::*; #(
	parameter int CRC_WIDTH = CCRC_DEFAULT_WIDTH
) (
	input  logic [CRC_WIDTH-1:0] crc,
	input  logic [CRC_WIDTH-1:0] poly,
	input  logic [CRC_WIDTH-1:0] rpoly,
	input  logic [7:0]           data,
	input  logic                 reflect,
	output logic [CRC_WIDTH-1:0] next_crc
);

	logic [CRC_WIDTH-1:0] c;
	logic [7:0]           d;

	// eight bit steps unrolled, lsb first with right shifts when reflected
	always_comb begin
		c = crc;
		d = data;
		if (reflect) begin
			for (int k = 0; k < 8; k++) begin
				if (c[0] ^ d[0])
					c = (c >> 1) ^ rpoly;
				else
					c = c >> 1;
				d = d >> 1;
			end
		end else begin
			c[CRC_WIDTH-1 -: 8] = c[CRC_WIDTH-1 -: 8] ^ data;
			for (int k = 0; k < 8; k++) begin
				if (c[CRC_WIDTH-1])
					c = (c << 1) ^ poly;
				else
					c = c << 1;
			end
		end
		next_crc = c;
	end

endmodule

// ===== hdl/configurable_crc_engine_unit.sv =====
// result path: an accepted last byte passes the input stage, then the result register, before its crc is on m_axis
// throughput: one byte per cycle; ready drops only while a finished crc waits behind
// a stalled output and the next item is itself a last byte
// reset: settings return to poly 0x04C11DB7, init 0xFFFFFFFF, no reflection;
// the crc register restarts from the initial value, no item is held
module configurable_crc_engine_unit import ccrc_pkg::*; #(
	parameter int CRC_WIDTH = CCRC_DEFAULT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // [7:0] data_byte
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [31:0]            m_axis_tdata,  // [31:0] crc_value
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [CCRC_ADDR_W-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int CW = (CRC_WIDTH < 32) ? CRC_WIDTH : 32;

	function automatic logic [CRC_WIDTH-1:0] rev_w(input logic [CRC_WIDTH-1:0] v);
		logic [CRC_WIDTH-1:0] r;
		for (int i = 0; i < CRC_WIDTH; i++)
			r[i] = v[CRC_WIDTH-1-i];
		return r;
	endfunction

	cfg_t                 cfg;
	logic [CRC_WIDTH-1:0] poly_w;
	logic [CRC_WIDTH-1:0] rpoly_w;
	logic [CRC_WIDTH-1:0] init_w;
	logic [CRC_WIDTH-1:0] start_val;
	logic [CRC_WIDTH-1:0] crc_cur;
	logic [CRC_WIDTH-1:0] next_crc;
	logic [CRC_WIDTH-1:0] final_crc;
	logic [CRC_WIDTH-1:0] crc_q;
	logic                 restart_q;
	logic                 v_s1;
	logic [7:0]           data_s1;
	logic                 last_s1;
	logic                 m_valid_q;
	logic [31:0]          m_data_q;
	logic                 out_free;
	logic                 fire;
	logic                 in_acc;

	ccrc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign poly_w    = CRC_WIDTH'(cfg.poly[CW-1:0]);
	assign init_w    = CRC_WIDTH'(cfg.init_crc[CW-1:0]);
	assign rpoly_w   = rev_w(poly_w);
	assign start_val = cfg.reflect_in ? rev_w(init_w) : init_w;

	// restart_q stands for a crc register holding the start value of the current settings
	assign crc_cur = restart_q ? start_val : crc_q;

	ccrc_byte_step #(.CRC_WIDTH(CRC_WIDTH)) u_step (
		.crc      (crc_cur),
		.poly     (poly_w),
		.rpoly    (rpoly_w),
		.data     (data_s1),
		.reflect  (cfg.reflect_in),
		.next_crc (next_crc)
	);

	assign final_crc = (cfg.reflect_in != cfg.reflect_out) ? rev_w(next_crc) : next_crc;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign fire          = v_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !v_s1 || fire;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			restart_q <= 1'b1;
			m_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				v_s1 <= s_axis_tvalid;
			if (cfg.wr)
				restart_q <= 1'b1;
			else if (fire)
				restart_q <= last_s1;
			if (fire && last_s1)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (fire)
			crc_q <= next_crc;
		if (fire && last_s1)
			m_data_q <= 32'(final_crc);
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> restart_q)
		else $error("crc register not restarted after a last item");

	a_restart_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.wr |=> restart_q)
		else $error("crc register not restarted after a register write");

	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> m_valid_q)
		else $error("finished crc not presented");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> v_s1 && last_s1 && m_valid_q && !m_axis_tready)
		else $error("input stalled without a blocked result");

endmodule
